// ----- rtl/motor_command_frame_decoder_assert.svh -----
// assertion macros used by the checker file
`ifndef MOTOR_COMMAND_FRAME_DECODER_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_DECODER_ASSERT_SVH

// property checked at every clock edge outside reset
`define MCFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define MCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/mcfd_pkg.sv -----
`default_nettype none

package mcfd_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_word_t;

    typedef struct packed {
        logic [1:0] frame_status;
        logic [9:0] drive_level_out;
        logic       over_limit;
        logic       left_fwd;
        logic       left_rev;
        logic       right_fwd;
        logic       right_rev;
    } res_word_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] speed_scale;
        logic [9:0] level_limit;
    } cfg_t;

    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    localparam logic [7:0] HEADER_RESET = 8'h53;
    localparam logic [7:0] SCALE_RESET  = 8'd100;
    localparam logic [9:0] LIMIT_RESET  = 10'd800;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;

    localparam logic [7:0] CMD_GO      = 8'h67;
    localparam logic [7:0] CMD_FORWARD = 8'h66;
    localparam logic [7:0] CMD_LEFT    = 8'h6C;
    localparam logic [7:0] CMD_RIGHT   = 8'h72;
    localparam logic [7:0] CMD_BACK    = 8'h62;
    localparam logic [7:0] CMD_STOP    = 8'h73;

    // bit 0 left_fwd, bit 1 left_rev, bit 2 right_fwd, bit 3 right_rev
    localparam logic [3:0] LINES_FORWARD = 4'b0101;
    localparam logic [3:0] LINES_LEFT    = 4'b0100;
    localparam logic [3:0] LINES_RIGHT   = 4'b0001;
    localparam logic [3:0] LINES_BACK    = 4'b1010;
    localparam logic [3:0] LINES_STOP    = 4'b0000;

endpackage

`default_nettype wire

// ----- rtl/mcfd_stream_if.sv -----
`default_nettype none

interface mcfd_stream_if #(
    parameter type word_t = logic [7:0]
) ();

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/motor_command_frame_decoder.sv -----
// Decodes motor command frames from a stream of received bytes, one byte per
// clock cycle while no checksum byte stalls. A frame is the header byte
// followed by command, speed and checksum bytes; each checksum byte yields one
// result word carrying the status, the low 10 bits of the drive level, the
// over-limit flag and the four H-bridge lines. A byte passes an input register
// and is decoded into the result register; the speed-times-scale product is
// registered as the speed byte goes through, ready for the checksum byte.
// Bytes keep flowing while a result word waits; only a checksum byte stalls,
// and only while the result register is full. Registers header_byte,
// speed_scale and level_limit sit at byte addresses 0, 4 and 8 of the APB
// port and should be written while idle.
`default_nettype none

module motor_command_frame_decoder
    import mcfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    mcfd_stream_if.sink            rx,
    mcfd_stream_if.source          res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_CMD,
        PH_SPEED,
        PH_SUM
    } phase_t;

    cfg_t       cfg;
    phase_t     phase_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic [7:0] cmd_reg;
    logic [7:0] speed_reg;
    logic [15:0] prod_reg;
    logic [15:0] drive_reg;
    logic [3:0] lines_reg;
    logic       out_valid_reg;
    res_word_t  out_word_reg;

    logic       out_free;
    logic       is_sum;
    logic       advance;
    logic       sum_ok;
    logic       known;
    logic       move;
    logic [3:0] cmd_lines;
    logic [1:0] status;
    logic [15:0] drive_next;
    logic [3:0] lines_next;
    logic [15:0] prod_next;
    res_word_t  word_next;

    mcfd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_free = !out_valid_reg || res.ready;
    assign is_sum   = (phase_reg == PH_SUM);
    assign advance  = s1_valid_reg && (!is_sum || out_free);
    assign rx.ready = !s1_valid_reg || advance;

    // 9-bit sum, no wrap
    assign sum_ok = ({1'b0, cmd_reg} + {1'b0, speed_reg}) == {1'b0, s1_byte_reg};

    always_comb
    begin
        known     = 1'b1;
        move      = 1'b1;
        cmd_lines = LINES_STOP;
        case (cmd_reg)
            CMD_GO:      cmd_lines = LINES_FORWARD;
            CMD_FORWARD: cmd_lines = LINES_FORWARD;
            CMD_LEFT:    cmd_lines = LINES_LEFT;
            CMD_RIGHT:   cmd_lines = LINES_RIGHT;
            CMD_BACK:    cmd_lines = LINES_BACK;
            CMD_STOP:    move = 1'b0;
            default:     known = 1'b0;
        endcase
    end

    always_comb
    begin
        if (!sum_ok)
        begin
            status = STATUS_CHECKSUM;
        end
        else if (!known)
        begin
            status = STATUS_UNKNOWN;
        end
        else
        begin
            status = STATUS_OK;
        end

        if (status == STATUS_OK)
        begin
            drive_next = move ? prod_reg : 16'd0;
            lines_next = cmd_lines;
        end
        else
        begin
            drive_next = drive_reg;
            lines_next = lines_reg;
        end

        word_next.frame_status    = status;
        word_next.drive_level_out = drive_next[9:0];
        word_next.over_limit      = drive_next > {6'd0, cfg.level_limit};
        word_next.left_fwd        = lines_next[0];
        word_next.left_rev        = lines_next[1];
        word_next.right_fwd       = lines_next[2];
        word_next.right_rev       = lines_next[3];
    end

    assign prod_next = {8'd0, s1_byte_reg} * {8'd0, cfg.speed_scale};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_HUNT;
            cmd_reg       <= 8'd0;
            speed_reg     <= 8'd0;
            drive_reg     <= 16'd0;
            lines_reg     <= LINES_STOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                s1_valid_reg <= 1'b1;
                s1_byte_reg  <= rx.data.rx_byte;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance && is_sum)
            begin
                out_valid_reg <= 1'b1;
                out_word_reg  <= word_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (s1_byte_reg == cfg.header_byte)
                        begin
                            phase_reg <= PH_CMD;
                        end
                    end
                    PH_CMD:
                    begin
                        cmd_reg   <= s1_byte_reg;
                        phase_reg <= PH_SPEED;
                    end
                    PH_SPEED:
                    begin
                        speed_reg <= s1_byte_reg;
                        prod_reg  <= prod_next;
                        phase_reg <= PH_SUM;
                    end
                    PH_SUM:
                    begin
                        drive_reg <= drive_next;
                        lines_reg <= lines_next;
                        phase_reg <= PH_HUNT;
                    end
                    default:
                    begin
                        phase_reg <= PH_HUNT;
                    end
                endcase
            end
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_word_reg;

endmodule

`default_nettype wire

// ----- rtl/mcfd_cfg_regs.sv -----
`default_nettype none

module mcfd_cfg_regs
    import mcfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [7:0] header_reg;
    logic [7:0] scale_reg;
    logic [9:0] limit_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            scale_reg  <= SCALE_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_HEADER: header_reg <= pwdata[7:0];
                REG_SCALE:  scale_reg  <= pwdata[7:0];
                REG_LIMIT:  limit_reg  <= pwdata[9:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HEADER: prdata = {{(DATA_W-8){1'b0}}, header_reg};
            REG_SCALE:  prdata = {{(DATA_W-8){1'b0}}, scale_reg};
            REG_LIMIT:  prdata = {{(DATA_W-10){1'b0}}, limit_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.header_byte = header_reg;
    assign cfg.speed_scale = scale_reg;
    assign cfg.level_limit = limit_reg;

endmodule

`default_nettype wire

// ----- rtl/mcfd_checker.sv -----
`default_nettype none

`include "motor_command_frame_decoder_assert.svh"

module mcfd_assert_checker
    import mcfd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      rx_ready,
    input wire logic      res_valid,
    input wire logic      res_ready,
    input wire res_word_t res_data
);

    `MCFD_ASSERT_NEXT(a_res_valid_held, clk, rst_n, res_valid && !res_ready, res_valid)
    `MCFD_ASSERT_NEXT(a_res_word_held, clk, rst_n, res_valid && !res_ready, $stable(res_data))
    `MCFD_ASSERT(a_ready_when_empty, clk, rst_n, !res_valid |-> rx_ready)
    `MCFD_ASSERT(a_left_not_both, clk, rst_n, res_valid |-> !(res_data.left_fwd && res_data.left_rev))
    `MCFD_ASSERT(a_right_not_both, clk, rst_n, res_valid |-> !(res_data.right_fwd && res_data.right_rev))

endmodule

bind motor_command_frame_decoder mcfd_assert_checker u_mcfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_ready  (rx.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);

`default_nettype wire
